### src/cbbb_pkg.sv
// Shared types and constants for the color blob bounding box block.
`default_nettype none
package cbbb_pkg;

    // Frame geometry bounds
    localparam int MAX_COLS = 2048;
    localparam int MAX_ROWS = 2048;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Fixed field widths
    localparam int FIELD_W  = 11;
    localparam int COLOR_W  = 8;
    localparam int LIMIT_W  = 9;
    localparam int SQ_W     = 2 * COLOR_W;
    localparam int DIST_W   = SQ_W + 2;
    localparam int LIM2_W   = 2 * LIMIT_W;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [COLOR_W-1:0] TARGET_RED_RST   = 8'd255;
    localparam logic [COLOR_W-1:0] TARGET_GREEN_RST = 8'd188;
    localparam logic [COLOR_W-1:0] TARGET_BLUE_RST  = 8'd47;
    localparam logic [LIMIT_W-1:0] DIST_LIMIT_RST   = 9'd50;

    // Mid queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_RED   = 2'd0,
        CFG_TARGET_GREEN = 2'd1,
        CFG_TARGET_BLUE  = 2'd2,
        CFG_DIST_LIMIT   = 2'd3
    } t_cfg_idx;

    // Classified pixel word passed from front to back
    typedef struct packed {
        logic             match;
        logic             eof;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_class;

    // Queue status seen by the producer and consumer
    typedef struct packed {
        logic full;
        logic valid;
    } t_qstat;

    // One frame result
    typedef struct packed {
        logic [FIELD_W-1:0] mid_col;
        logic [FIELD_W-1:0] center_row;
        logic [FIELD_W-1:0] box_left;
        logic [FIELD_W-1:0] box_right;
        logic [FIELD_W-1:0] box_top;
        logic [FIELD_W-1:0] box_bottom;
        logic               found;
    } t_result;

endpackage
`default_nettype wire

### src/cbbb_front.sv
// Front end: config registers, pixel position counters and color match test.
`default_nettype none
module cbbb_front
    import cbbb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0]   i_cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [COLOR_W-1:0]   i_red,
    input  wire logic [COLOR_W-1:0]   i_green,
    input  wire logic [COLOR_W-1:0]   i_blue,
    input  wire logic                 i_end_of_row,
    input  wire logic                 i_end_of_frame,
    input  wire t_qstat               i_qstat,
    output logic                      o_qpush,
    output t_class                    o_qword
);

    logic [COLOR_W-1:0] r_target_red, r_target_green, r_target_blue;
    logic [LIMIT_W-1:0] r_dist_limit;
    logic [LIM2_W-1:0]  r_lim2;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic             r_s1_valid;
    logic [SQ_W-1:0]  r_sq_r, r_sq_g, r_sq_b;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_eof;

    logic [COLOR_W-1:0] d_r, d_g, d_b;
    logic [DIST_W-1:0]  dist2;
    logic               accept;

    // Config register writes; unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_red   <= TARGET_RED_RST;
            r_target_green <= TARGET_GREEN_RST;
            r_target_blue  <= TARGET_BLUE_RST;
            r_dist_limit   <= DIST_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_RED:   r_target_red   <= i_cfg_data[COLOR_W-1:0];
                CFG_TARGET_GREEN: r_target_green <= i_cfg_data[COLOR_W-1:0];
                CFG_TARGET_BLUE:  r_target_blue  <= i_cfg_data[COLOR_W-1:0];
                CFG_DIST_LIMIT:   r_dist_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Squared limit, tracks the limit register in the next cycle
    always_ff @(posedge i_clk) begin
        r_lim2 <= LIM2_W'(r_dist_limit) * LIM2_W'(r_dist_limit);
    end

    // Stage holds while it is loaded and the queue is full
    assign full   = r_s1_valid && i_qstat.full;
    assign accept = push && !full;

    // Absolute channel differences
    always_comb begin
        d_r = (i_red   > r_target_red)   ? i_red   - r_target_red   : r_target_red   - i_red;
        d_g = (i_green > r_target_green) ? i_green - r_target_green : r_target_green - i_green;
        d_b = (i_blue  > r_target_blue)  ? i_blue  - r_target_blue  : r_target_blue  - i_blue;
    end

    // Position counters, advanced per accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (i_end_of_frame) begin
                r_col <= '0;
                r_row <= '0;
            end else if (i_end_of_row) begin
                r_col <= '0;
                if (r_row < ROW_W'(MAX_ROWS - 1)) r_row <= r_row + 1'b1;
            end else begin
                if (r_col < COL_W'(MAX_COLS - 1)) r_col <= r_col + 1'b1;
            end
        end
    end

    // Square stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!full) begin
            r_s1_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq_r   <= SQ_W'(d_r) * SQ_W'(d_r);
            r_sq_g   <= SQ_W'(d_g) * SQ_W'(d_g);
            r_sq_b   <= SQ_W'(d_b) * SQ_W'(d_b);
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_eof <= i_end_of_frame;
        end
    end

    // Sum and compare feed the queue directly
    assign dist2 = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    assign o_qpush       = r_s1_valid && !i_qstat.full;
    assign o_qword.match = dist2 < DIST_W'(r_lim2);
    assign o_qword.eof   = r_s1_eof;
    assign o_qword.col   = r_s1_col;
    assign o_qword.row   = r_s1_row;

endmodule
`default_nettype wire

### src/cbbb_queue.sv
// Short queue of classified pixel words between front and back.
`default_nettype none
module cbbb_queue
    import cbbb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_class i_word,
    input  wire logic   i_pop,
    output t_qstat      o_stat,
    output t_class      o_word
);

    t_class             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.valid = (r_cnt != '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.valid;
    assign o_word       = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_word;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### src/cbbb_back.sv
// Back end: bounding box accumulation and the frame result register.
`default_nettype none
module cbbb_back
    import cbbb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_qstat i_qstat,
    input  wire t_class i_qword,
    output logic      o_qpop,
    output logic      empty,
    input  wire logic pop,
    output t_result   o_result
);

    logic [COL_W-1:0] r_min_col, r_max_col;
    logic [ROW_W-1:0] r_min_row, r_max_row;
    logic             r_any;
    logic             r_out_valid;
    t_result          r_out;

    logic             out_free;
    logic [COL_W-1:0] n_min_col, n_max_col;
    logic [ROW_W-1:0] n_min_row, n_max_row;
    logic             n_any;
    logic [COL_W:0]   col_sum;
    logic [ROW_W:0]   row_sum;
    t_result          frame_res;

    assign out_free = !r_out_valid || pop;
    assign o_qpop   = i_qstat.valid && (!i_qword.eof || out_free);
    assign empty    = !r_out_valid;
    assign o_result = r_out;

    // Box merged with the current word
    always_comb begin
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_any     = r_any;
        if (i_qword.match) begin
            if (i_qword.col < r_min_col) n_min_col = i_qword.col;
            if (i_qword.col > r_max_col) n_max_col = i_qword.col;
            if (i_qword.row < r_min_row) n_min_row = i_qword.row;
            if (i_qword.row > r_max_row) n_max_row = i_qword.row;
            n_any = 1'b1;
        end
    end

    // Frame result; all zero with no match
    always_comb begin
        col_sum = {1'b0, n_min_col} + {1'b0, n_max_col};
        row_sum = {1'b0, n_min_row} + {1'b0, n_max_row};
        frame_res = '0;
        if (n_any) begin
            frame_res.mid_col    = FIELD_W'(col_sum[COL_W:1]);
            frame_res.center_row = FIELD_W'(row_sum[ROW_W:1]);
            frame_res.box_left   = FIELD_W'(n_min_col);
            frame_res.box_right  = FIELD_W'(n_max_col);
            frame_res.box_top    = FIELD_W'(n_min_row);
            frame_res.box_bottom = FIELD_W'(n_max_row);
            frame_res.found      = 1'b1;
        end
    end

    // Accumulator state, cleared at end of frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_col <= '1;
            r_max_col <= '0;
            r_min_row <= '1;
            r_max_row <= '0;
            r_any     <= 1'b0;
        end else if (o_qpop) begin
            if (i_qword.eof) begin
                r_min_col <= '1;
                r_max_col <= '0;
                r_min_row <= '1;
                r_max_row <= '0;
                r_any     <= 1'b0;
            end else begin
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
                r_any     <= n_any;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_qpop && i_qword.eof) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_qpop && i_qword.eof) r_out <= frame_res;
    end

endmodule
`default_nettype wire

### src/color_blob_bounding_box.sv
// Color blob bounding box: a pixel passes the square stage register and the queue, and the
// frame result is registered at end of frame. One pixel per cycle while full is low.
// A result word waits in the output register; a new frame result enters as it is popped.
// Synchronous active-low reset restores the register defaults and clears the box state.
// No clearing pass: the block takes pixels as soon as reset is released.
`default_nettype none
module color_blob_bounding_box
    import cbbb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0]   i_cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [COLOR_W-1:0]   i_red,
    input  wire logic [COLOR_W-1:0]   i_green,
    input  wire logic [COLOR_W-1:0]   i_blue,
    input  wire logic                 i_end_of_row,
    input  wire logic                 i_end_of_frame,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [FIELD_W-1:0]        o_mid_col,
    output logic [FIELD_W-1:0]        o_center_row,
    output logic [FIELD_W-1:0]        o_box_left,
    output logic [FIELD_W-1:0]        o_box_right,
    output logic [FIELD_W-1:0]        o_box_top,
    output logic [FIELD_W-1:0]        o_box_bottom,
    output logic                      o_found
);

    t_qstat  qstat;
    logic    qpush, qpop;
    t_class  qword_in, qword_out;
    t_result result;

    cbbb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_end_of_row   (i_end_of_row),
        .i_end_of_frame (i_end_of_frame),
        .i_qstat        (qstat),
        .o_qpush        (qpush),
        .o_qword        (qword_in)
    );

    cbbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (qpush),
        .i_word  (qword_in),
        .i_pop   (qpop),
        .o_stat  (qstat),
        .o_word  (qword_out)
    );

    cbbb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (qstat),
        .i_qword  (qword_out),
        .o_qpop   (qpop),
        .empty    (empty),
        .pop      (pop),
        .o_result (result)
    );

    assign o_mid_col    = result.mid_col;
    assign o_center_row = result.center_row;
    assign o_box_left   = result.box_left;
    assign o_box_right  = result.box_right;
    assign o_box_top    = result.box_top;
    assign o_box_bottom = result.box_bottom;
    assign o_found      = result.found;

endmodule
`default_nettype wire

### src/cbbb_checker.sv
// Port-level checks for the color blob bounding box, bound to the top level.
`default_nettype none
module cbbb_checker
    import cbbb_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic [FIELD_W-1:0] o_mid_col,
    input wire logic [FIELD_W-1:0] o_center_row,
    input wire logic [FIELD_W-1:0] o_box_left,
    input wire logic [FIELD_W-1:0] o_box_right,
    input wire logic [FIELD_W-1:0] o_box_top,
    input wire logic [FIELD_W-1:0] o_box_bottom,
    input wire logic               o_found
);

    // Reset leaves no result word waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // A frame with no match reports an all-zero box
    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_found) |-> (o_box_left == '0 && o_box_right == '0 &&
            o_box_top == '0 && o_box_bottom == '0 &&
            o_mid_col == '0 && o_center_row == '0))
        else $error("no-match result is not zero");

    // Center lies inside an ordered box
    a_center_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_found) |-> (o_box_left <= o_mid_col &&
            o_mid_col <= o_box_right && o_box_top <= o_center_row &&
            o_center_row <= o_box_bottom))
        else $error("center outside the bounding box");

    // A waiting word holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_box_left) && $stable(o_found)))
        else $error("waiting result word changed");

endmodule

bind color_blob_bounding_box cbbb_checker u_cbbb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_mid_col    (o_mid_col),
    .o_center_row (o_center_row),
    .o_box_left   (o_box_left),
    .o_box_right  (o_box_right),
    .o_box_top    (o_box_top),
    .o_box_bottom (o_box_bottom),
    .o_found      (o_found)
);
`default_nettype wire

### test/tb_color_blob_bounding_box.sv
// Self-checking testbench for the color blob bounding box block.
`timescale 1ns / 1ps

module tb_color_blob_bounding_box;
    import cbbb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    // Receiver stall patterns
    typedef enum {POP_ALWAYS, POP_RANDOM, POP_BURSTY} t_pop_style;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LIMIT_W-1:0]   i_cfg_data;
    logic                 push;
    logic                 full;
    logic [COLOR_W-1:0]   i_red;
    logic [COLOR_W-1:0]   i_green;
    logic [COLOR_W-1:0]   i_blue;
    logic                 i_end_of_row;
    logic                 i_end_of_frame;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [FIELD_W-1:0]   o_mid_col;
    logic [FIELD_W-1:0]   o_center_row;
    logic [FIELD_W-1:0]   o_box_left;
    logic [FIELD_W-1:0]   o_box_right;
    logic [FIELD_W-1:0]   o_box_top;
    logic [FIELD_W-1:0]   o_box_bottom;
    logic                 o_found;

    color_blob_bounding_box dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_end_of_row   (i_end_of_row),
        .i_end_of_frame (i_end_of_frame),
        .empty          (empty),
        .pop            (pop),
        .o_mid_col      (o_mid_col),
        .o_center_row   (o_center_row),
        .o_box_left     (o_box_left),
        .o_box_right    (o_box_right),
        .o_box_top      (o_box_top),
        .o_box_bottom   (o_box_bottom),
        .o_found        (o_found)
    );

    always #1 i_clk = ~i_clk;

    // Shared run state
    t_result    expected_boxes[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         frames_sent = 0;
    int         burst_left  = 0;
    int         gap_max     = 0;
    t_pop_style pop_mode    = POP_ALWAYS;

    // Model of the block: registers and per-frame tracking
    logic [COLOR_W-1:0] tgt_red, tgt_green, tgt_blue;
    logic [LIMIT_W-1:0] tgt_limit;
    int  cur_col, cur_row, lo_col, hi_col, lo_row, hi_row;
    bit  seen_match;

    function automatic void clear_box_state();
        cur_col    = 0;
        cur_row    = 0;
        lo_col     = 32'h7FFF_FFFF;
        hi_col     = 0;
        lo_row     = 32'h7FFF_FFFF;
        hi_row     = 0;
        seen_match = 1'b0;
    endfunction

    // Track one pixel; returns 1 with the frame box when the frame closes
    function automatic bit track_pixel(input logic [COLOR_W-1:0] r, g, b,
                                       input bit eor, eof, output t_result box);
        int dr, dg, db, dist2, lim2;
        dr    = int'(r) - int'(tgt_red);
        dg    = int'(g) - int'(tgt_green);
        db    = int'(b) - int'(tgt_blue);
        dist2 = dr * dr + dg * dg + db * db;
        lim2  = int'(tgt_limit) * int'(tgt_limit);
        box   = '0;
        if (dist2 < lim2) begin
            if (cur_col < lo_col) lo_col = cur_col;
            if (cur_col > hi_col) hi_col = cur_col;
            if (cur_row < lo_row) lo_row = cur_row;
            if (cur_row > hi_row) hi_row = cur_row;
            seen_match = 1'b1;
        end
        if (eof) begin
            if (seen_match) begin
                box.mid_col    = FIELD_W'((lo_col + hi_col) >> 1);
                box.center_row = FIELD_W'((lo_row + hi_row) >> 1);
                box.box_left   = FIELD_W'(lo_col);
                box.box_right  = FIELD_W'(hi_col);
                box.box_top    = FIELD_W'(lo_row);
                box.box_bottom = FIELD_W'(hi_row);
                box.found      = 1'b1;
            end
            clear_box_state();
            return 1'b1;
        end
        // Position counters saturate at the frame bounds
        if (eor) begin
            cur_col = 0;
            if (cur_row < MAX_ROWS - 1) cur_row++;
        end else if (cur_col < MAX_COLS - 1) begin
            cur_col++;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(string field_name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s expected %0d, got %0d", $time, field_name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // Send one pixel word; with gap_max set, the sender idles between bursts of random length
    task automatic send_pixel(input logic [COLOR_W-1:0] r, g, b, input bit eor, eof);
        t_result box;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max > 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
        end
        burst_left--;
        push           <= 1'b1;
        i_red          <= r;
        i_green        <= g;
        i_blue         <= b;
        i_end_of_row   <= eor;
        i_end_of_frame <= eof;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (track_pixel(r, g, b, eor, eof, box)) begin
            expected_boxes.push_back(box);
            frames_sent++;
        end
    endtask

    // Stop sending until every frame result is out and the pipeline is quiet
    task automatic drain_results();
        push <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [LIMIT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_TARGET_RED:   tgt_red   = value[COLOR_W-1:0];
            CFG_TARGET_GREEN: tgt_green = value[COLOR_W-1:0];
            CFG_TARGET_BLUE:  tgt_blue  = value[COLOR_W-1:0];
            CFG_DIST_LIMIT:   tgt_limit = value;
            default: ;
        endcase
    endtask

    // Write all four registers; color data may carry a stray top bit
    task automatic set_config(input logic [LIMIT_W-1:0] r, g, b, lim);
        drain_results();
        write_reg(CFG_TARGET_RED, r);
        write_reg(CFG_TARGET_GREEN, g);
        write_reg(CFG_TARGET_BLUE, b);
        write_reg(CFG_DIST_LIMIT, lim);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COLOR_W-1:0] near_color(input int center, input int spread);
        int v;
        v = center + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return COLOR_W'(v);
    endfunction

    // Reset register values: exact hit, miss, distance just at and under the limit
    task automatic test_default_target();
        gap_max  = 0;
        pop_mode = POP_ALWAYS;
        send_pixel(8'd255, 8'd188, 8'd47, 1'b0, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd138, 8'd47, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd139, 8'd47, 1'b1, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd188, 8'd47, 1'b1, 1'b1);
        drain_results();
    endtask

    // Zero limit, limit above the largest distance, and the far-corner boundary
    task automatic test_register_extremes();
        pop_mode = POP_RANDOM;
        set_config(9'h1FF, 9'h100, 9'h000, 9'd0);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b1);
        set_config(9'h100, 9'h000, 9'h100, 9'd511);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
        send_pixel(8'd170, 8'd85, 8'd170, 1'b0, 1'b0);
        send_pixel(8'd85, 8'd170, 8'd85, 1'b1, 1'b1);
        set_config(9'd255, 9'd255, 9'd255, 9'd441);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
        set_config(9'd255, 9'd255, 9'd255, 9'd442);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
        set_config(9'd255, 9'd255, 9'd255, 9'd443);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
        drain_results();
    endtask

    // Rows longer than the column bound share the last column
    task automatic test_long_row();
        gap_max  = 3;
        pop_mode = POP_BURSTY;
        set_config(9'd128, 9'd64, 9'd200, 9'd1);
        for (int k = 0; k < 2100; k++) begin
            if (k == 5 || k == 2060)
                send_pixel(8'd128, 8'd64, 8'd200, 1'b0, 1'b0);
            else
                send_pixel(COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                           COLOR_W'($urandom_range(0, 255)), k == 2099, 1'b0);
        end
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd128, 8'd64, 8'd200, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
        // Only a saturated-column hit: box collapses onto the last column
        for (int k = 0; k < 2050; k++) begin
            if (k == 2049)
                send_pixel(8'd128, 8'd64, 8'd200, 1'b0, 1'b1);
            else
                send_pixel(8'd127, 8'd63, 8'd199, 1'b0, 1'b0);
        end
        drain_results();
    endtask

    // More rows than the row bound share the last row
    task automatic test_many_rows();
        gap_max  = 2;
        pop_mode = POP_RANDOM;
        for (int k = 0; k < 2100; k++) begin
            if (k == 3 || k == 2080)
                send_pixel(8'd128, 8'd64, 8'd200, 1'b1, 1'b0);
            else
                send_pixel(COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                           COLOR_W'($urandom_range(0, 255)), 1'b1, k == 2099);
        end
        drain_results();
    endtask

    // Random frames, mostly well formed, with some pixels near the target color
    task automatic test_random_frames();
        int pixels_sent, start_frames, width, height, spread, count;
        bit eof;
        pixels_sent  = 0;
        start_frames = frames_sent;
        while (pixels_sent < 700 || frames_sent - start_frames < 40) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0: set_config(LIMIT_W'($urandom_range(0, 511)),
                                  LIMIT_W'($urandom_range(0, 511)),
                                  LIMIT_W'($urandom_range(0, 511)), 9'd0);
                    1: set_config(LIMIT_W'($urandom_range(0, 511)),
                                  LIMIT_W'($urandom_range(0, 511)),
                                  LIMIT_W'($urandom_range(0, 511)), 9'd511);
                    2: set_config(LIMIT_W'($urandom_range(0, 511)),
                                  LIMIT_W'($urandom_range(0, 511)),
                                  LIMIT_W'($urandom_range(0, 511)),
                                  LIMIT_W'($urandom_range(1, 443)));
                    default: set_config(LIMIT_W'($urandom_range(0, 511)),
                                        LIMIT_W'($urandom_range(0, 511)),
                                        LIMIT_W'($urandom_range(0, 511)),
                                        LIMIT_W'($urandom_range(5, 80)));
                endcase
            end
            if ($urandom_range(0, 3) == 0) begin
                gap_max  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(2, 10);
                pop_mode = t_pop_style'($urandom_range(0, 2));
            end
            spread = int'(tgt_limit) / 2 + 2;
            if ($urandom_range(0, 7) == 0) begin
                // Noise: stray row marks, frame may stay open into the next one
                count = $urandom_range(1, 20);
                for (int k = 0; k < count; k++) begin
                    eof = (k == count - 1) ? ($urandom_range(0, 1) == 0)
                                           : ($urandom_range(0, 9) == 0);
                    send_pixel(COLOR_W'($urandom_range(0, 255)),
                               COLOR_W'($urandom_range(0, 255)),
                               COLOR_W'($urandom_range(0, 255)),
                               $urandom_range(0, 2) == 0, eof);
                end
                pixels_sent += count;
            end else begin
                width  = $urandom_range(1, 10);
                height = $urandom_range(1, 5);
                for (int y = 0; y < height; y++) begin
                    for (int x = 0; x < width; x++) begin
                        eof = (y == height - 1) && (x == width - 1);
                        if ($urandom_range(0, 3) == 0)
                            send_pixel(near_color(int'(tgt_red), spread),
                                       near_color(int'(tgt_green), spread),
                                       near_color(int'(tgt_blue), spread),
                                       (x == width - 1) && (!eof || $urandom_range(0, 1)),
                                       eof);
                        else
                            send_pixel(COLOR_W'($urandom_range(0, 255)),
                                       COLOR_W'($urandom_range(0, 255)),
                                       COLOR_W'($urandom_range(0, 255)),
                                       (x == width - 1) && (!eof || $urandom_range(0, 1)),
                                       eof);
                    end
                end
                pixels_sent += width * height;
            end
        end
        drain_results();
    endtask

    // Result checker and receiver stall pattern
    always @(posedge i_clk) begin : result_check
        t_result exp_box;
        if (i_rst_n && pop && !empty) begin
            if (expected_boxes.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got found=%0b box=%0d..%0d",
                         $time, o_found, o_box_left, o_box_right);
                error_count++;
            end else begin
                exp_box = expected_boxes.pop_front();
                check_field("mid_col", int'(exp_box.mid_col), int'(o_mid_col));
                check_field("center_row", int'(exp_box.center_row), int'(o_center_row));
                check_field("box_left", int'(exp_box.box_left), int'(o_box_left));
                check_field("box_right", int'(exp_box.box_right), int'(o_box_right));
                check_field("box_top", int'(exp_box.box_top), int'(o_box_top));
                check_field("box_bottom", int'(exp_box.box_bottom), int'(o_box_bottom));
                check_field("found", int'(exp_box.found), int'(o_found));
            end
        end
        case (pop_mode)
            POP_ALWAYS: pop <= 1'b1;
            POP_RANDOM: pop <= ($urandom_range(0, 3) != 0);
            default:    pop <= ((cycle_count % 48) >= 30);
        endcase
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_TARGET_RED;
        i_cfg_data     <= '0;
        push           <= 1'b0;
        i_red          <= '0;
        i_green        <= '0;
        i_blue         <= '0;
        i_end_of_row   <= 1'b0;
        i_end_of_frame <= 1'b0;
        tgt_red   = TARGET_RED_RST;
        tgt_green = TARGET_GREEN_RST;
        tgt_blue  = TARGET_BLUE_RST;
        tgt_limit = DIST_LIMIT_RST;
        clear_box_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_target();
        test_register_extremes();
        test_long_row();
        test_many_rows();
        test_random_frames();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### color_blob_bounding_box.f
src/cbbb_pkg.sv
src/cbbb_front.sv
src/cbbb_queue.sv
src/cbbb_back.sv
src/color_blob_bounding_box.sv
src/cbbb_checker.sv
test/tb_color_blob_bounding_box.sv
